>>> rtl/core/xorshift128_random_source_top_assert.svh
// Assertion macros shared by the random source RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef XORSHIFT128_RANDOM_SOURCE_TOP_ASSERT_SVH
`define XORSHIFT128_RANDOM_SOURCE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define XRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xrs: same-cycle check failed");

// next-cycle implication, checked out of reset
`define XRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xrs: next-cycle check failed");

`endif

>>> rtl/core/xrs_pkg.sv
// Shared types and constants for the xorshift128 random source.
// No dependencies; imported by xrs_gen, xrs_scale and the top level.
`timescale 1ns / 1ps

package xrs_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned CMD_W  = 3;
    localparam int unsigned POS_W  = 6;

    localparam logic [WORD_W-1:0] Y_INIT = 32'd842502087;
    localparam logic [WORD_W-1:0] Z_INIT = 32'd3579807591;
    localparam logic [WORD_W-1:0] W_INIT = 32'd273326509;
    localparam logic [WORD_W-1:0] MASK31 = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0]  BIT_POS_FULL = 6'd32;
    localparam logic [POS_W-1:0]  BIT_POS_FIRST = 6'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_RAW    = 3'd0,
        CMD_MASK31 = 3'd1,
        CMD_SCALE  = 3'd2,
        CMD_RANGE  = 3'd3,
        CMD_BOOL   = 3'd4
    } t_cmd;

    // one item after the draw stage
    typedef struct packed {
        t_cmd               cmd;
        logic [WORD_W-1:0]  word;   // final word field (raw, masked, bit or zero)
        logic [WORD_W-1:0]  v31;    // 31-bit value for scaling, bit 31 clear
        logic [WORD_W-1:0]  base;   // lower bound for range, zero for scale
        logic [WORD_W:0]    diff;   // exact 33-bit bound difference
    } t_gen_item;

endpackage

>>> rtl/core/xrs_gen.sv
// Draw stage: seed register, xorshift128 state, bit buffer and first item register.
// Depends on xrs_pkg.
`timescale 1ns / 1ps
`include "xorshift128_random_source_top_assert.svh"

module xrs_gen (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [xrs_pkg::WORD_W-1:0]   i_cfg_seed,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [xrs_pkg::CMD_W-1:0]    i_command,
    input  logic [xrs_pkg::WORD_W-1:0]   i_lower_bound,
    input  logic [xrs_pkg::WORD_W-1:0]   i_upper_bound,
    output logic                         o_valid,
    input  logic                         i_take,
    output xrs_pkg::t_gen_item           o_item
);
    import xrs_pkg::*;

    logic [WORD_W-1:0] r_seed, n_seed;
    logic [WORD_W-1:0] r_x, r_y, r_z, r_w;
    logic [WORD_W-1:0] n_x, n_y, n_z, n_w;
    logic [WORD_W-1:0] r_buf, n_buf;
    logic [POS_W-1:0]  r_bit_pos, n_bit_pos;
    logic              r_valid, n_valid;
    t_gen_item         r_item, n_item;

    logic              w_accept;
    logic [WORD_W-1:0] w_t;
    logic [WORD_W-1:0] w_draw;
    t_cmd              w_cmd;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = r_valid && !i_take;
    assign w_cmd      = t_cmd'(i_command);

    assign w_t    = r_x ^ (r_x << 11);
    assign w_draw = r_w ^ (r_w >> 19) ^ w_t ^ (w_t >> 8);

    always_comb begin
        n_seed    = r_seed;
        n_x       = r_x;
        n_y       = r_y;
        n_z       = r_z;
        n_w       = r_w;
        n_buf     = r_buf;
        n_bit_pos = r_bit_pos;
        if (i_cfg_we) begin
            n_seed    = i_cfg_seed;
            n_x       = i_cfg_seed;
            n_y       = Y_INIT;
            n_z       = Z_INIT;
            n_w       = W_INIT;
            n_buf     = '0;
            n_bit_pos = BIT_POS_FULL;
        end else if (w_accept) begin
            case (w_cmd)
                CMD_RAW, CMD_MASK31, CMD_SCALE, CMD_RANGE: begin
                    n_x = r_y;
                    n_y = r_z;
                    n_z = r_w;
                    n_w = w_draw;
                end
                CMD_BOOL: begin
                    if (r_bit_pos >= BIT_POS_FULL) begin
                        n_x       = r_y;
                        n_y       = r_z;
                        n_z       = r_w;
                        n_w       = w_draw;
                        n_buf     = w_draw;
                        n_bit_pos = BIT_POS_FIRST;
                    end else begin
                        n_buf     = r_buf >> 1;
                        n_bit_pos = r_bit_pos + BIT_POS_FIRST;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // item fields for the scaling stages
    always_comb begin
        n_item.cmd  = w_cmd;
        n_item.word = '0;
        n_item.v31  = w_draw & MASK31;
        n_item.base = '0;
        n_item.diff = {i_upper_bound[WORD_W-1], i_upper_bound};
        case (w_cmd)
            CMD_RAW:    n_item.word = w_draw;
            CMD_MASK31: n_item.word = w_draw & MASK31;
            CMD_SCALE: begin
            end
            CMD_RANGE: begin
                n_item.base = i_lower_bound;
                n_item.diff = {i_upper_bound[WORD_W-1], i_upper_bound}
                            - {i_lower_bound[WORD_W-1], i_lower_bound};
            end
            CMD_BOOL: begin
                if (r_bit_pos >= BIT_POS_FULL) begin
                    n_item.word = {{(WORD_W-1){1'b0}}, w_draw[0]};
                end else begin
                    n_item.word = {{(WORD_W-1){1'b0}}, r_buf[1]};
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed    <= '0;
            r_x       <= '0;
            r_y       <= Y_INIT;
            r_z       <= Z_INIT;
            r_w       <= W_INIT;
            r_buf     <= '0;
            r_bit_pos <= BIT_POS_FULL;
            r_valid   <= 1'b0;
        end else begin
            r_seed    <= n_seed;
            r_x       <= n_x;
            r_y       <= n_y;
            r_z       <= n_z;
            r_w       <= n_w;
            r_buf     <= n_buf;
            r_bit_pos <= n_bit_pos;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    // bit position only counts up to the refill mark
    `XRS_ASSERT_NOW(a_bit_pos_range, i_clk, i_rst_n, 1'b1, r_bit_pos <= BIT_POS_FULL)
    // a seed write restores the fixed state words and the empty bit buffer
    `XRS_ASSERT_NEXT(a_cfg_reinit, i_clk, i_rst_n, i_cfg_we,
        r_y == Y_INIT && r_z == Z_INIT && r_w == W_INIT && r_bit_pos == BIT_POS_FULL
        && r_x == r_seed)

endmodule

>>> rtl/core/xrs_scale.sv
// Scaling stages: 32x33 signed product register, then truncating add into the result register.
// Depends on xrs_pkg.
`timescale 1ns / 1ps
`include "xorshift128_random_source_top_assert.svh"

module xrs_scale (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_take,
    input  xrs_pkg::t_gen_item           i_item,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [xrs_pkg::WORD_W-1:0]   o_word,
    output logic [xrs_pkg::WORD_W-1:0]   o_scaled
);
    import xrs_pkg::*;

    localparam int unsigned PROD_W = 2 * WORD_W;
    localparam int unsigned SUM_W  = WORD_W + 2;

    // product stage
    logic                     r_p_valid, n_p_valid;
    t_cmd                     r_p_cmd;
    logic [WORD_W-1:0]        r_p_word;
    logic [WORD_W-1:0]        r_p_base;
    logic signed [PROD_W-1:0] r_prod;

    // result stage
    logic                     r_o_valid, n_o_valid;
    t_cmd                     r_o_cmd;
    logic [WORD_W-1:0]        r_o_word;
    logic [WORD_W-1:0]        r_o_scaled;

    logic                     w_load_p;
    logic                     w_load_o;
    logic signed [WORD_W-1:0] w_v_s;
    logic signed [WORD_W:0]   w_diff_s;
    logic signed [PROD_W-1:0] w_prod;
    logic [WORD_W:0]          w_hi;
    logic [SUM_W-1:0]         w_sum;
    logic [SUM_W-1:0]         w_total;
    logic                     w_frac;
    logic [WORD_W-1:0]        n_scaled;

    assign w_load_o = !r_o_valid || !i_out_stall;
    assign w_load_p = !r_p_valid || w_load_o;
    assign o_take   = w_load_p;

    assign w_v_s    = signed'(i_item.v31);
    assign w_diff_s = signed'(i_item.diff);
    // |v * diff| < 2^63, so the signed product fits in 64 bits
    assign w_prod   = w_v_s * w_diff_s;

    // floor of product / 2^31, then move toward zero when a negative sum has a fraction
    assign w_hi    = r_prod[PROD_W-1:WORD_W-1];
    assign w_frac  = |r_prod[WORD_W-2:0];
    assign w_sum   = {{2{r_p_base[WORD_W-1]}}, r_p_base} + {w_hi[WORD_W], w_hi};
    assign w_total = w_sum + {{(SUM_W-1){1'b0}}, (w_sum[SUM_W-1] && w_frac)};

    always_comb begin
        n_scaled = '0;
        case (r_p_cmd)
            CMD_SCALE, CMD_RANGE: n_scaled = w_total[WORD_W-1:0];
            default:              n_scaled = '0;
        endcase
    end

    always_comb begin
        n_p_valid = r_p_valid;
        if (w_load_p) begin
            n_p_valid = i_valid;
        end
        n_o_valid = r_o_valid;
        if (w_load_o) begin
            n_o_valid = r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_p_valid <= n_p_valid;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_p && i_valid) begin
            r_p_cmd  <= i_item.cmd;
            r_p_word <= i_item.word;
            r_p_base <= i_item.base;
            r_prod   <= w_prod;
        end
        if (w_load_o && r_p_valid) begin
            r_o_cmd    <= r_p_cmd;
            r_o_word   <= r_p_word;
            r_o_scaled <= n_scaled;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_word      = r_o_word;
    assign o_scaled    = r_o_scaled;

    // scaled result only for the scaling commands
    `XRS_ASSERT_NOW(a_scaled_zero, i_clk, i_rst_n,
        r_o_valid && r_o_cmd != CMD_SCALE && r_o_cmd != CMD_RANGE, r_o_scaled == '0)
    // boolean results carry a single bit
    `XRS_ASSERT_NOW(a_bool_bit, i_clk, i_rst_n,
        r_o_valid && r_o_cmd == CMD_BOOL, r_o_word[WORD_W-1:1] == '0)

endmodule

>>> rtl/core/xorshift128_random_source_top.sv
// Channel   | dir | handshake               | payload
// request   | in  | i_in_valid / o_in_stall | i_command, i_lower_bound, i_upper_bound
// result    | out | o_out_valid / i_out_stall | o_word, o_scaled
// seed cfg  | in  | i_cfg_we                | i_cfg_seed
//
// One request per cycle while o_in_stall is low; each result passes through three
// register stages (draw, product, truncating add) and is held in the last of them.
// The state update is an xor/shift loop on the four state words.
// Synchronous active-low reset: seed 0, fixed state words, empty bit buffer.
// A seed write reloads the seed, state words and bit buffer. An output stall
// backs up the three stages and then stalls the request side.
`timescale 1ns / 1ps

module xorshift128_random_source_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [xrs_pkg::WORD_W-1:0]   i_cfg_seed,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [xrs_pkg::CMD_W-1:0]    i_command,
    input  logic [xrs_pkg::WORD_W-1:0]   i_lower_bound,
    input  logic [xrs_pkg::WORD_W-1:0]   i_upper_bound,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [xrs_pkg::WORD_W-1:0]   o_word,
    output logic [xrs_pkg::WORD_W-1:0]   o_scaled
);
    import xrs_pkg::*;

    logic      w_gen_valid;
    logic      w_take;
    t_gen_item w_item;

    xrs_gen u_gen (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_seed    (i_cfg_seed),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_lower_bound (i_lower_bound),
        .i_upper_bound (i_upper_bound),
        .o_valid       (w_gen_valid),
        .i_take        (w_take),
        .o_item        (w_item)
    );

    xrs_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_gen_valid),
        .o_take      (w_take),
        .i_item      (w_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_word      (o_word),
        .o_scaled    (o_scaled)
    );

endmodule

>>> tb/tb_xorshift128_random_source_top.sv
// Self-checking testbench for xorshift128_random_source_top: drives requests and seed writes,
// predicts every result from a local xorshift128 model and checks each transfer.
// Depends on xrs_pkg and the top level RTL only.
`timescale 1ns / 1ps

module tb_xorshift128_random_source_top;
    import xrs_pkg::*;

    localparam int LATENCY = 3;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
    localparam logic [WORD_W-1:0] S32_MIN = 32'h8000_0000;
    localparam logic [WORD_W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic signed [71:0] Q31_ONE = 72'sd2147483648;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] scaled;
    } t_answer;

    // Generator state mirror plus the results still owed by the block.
    class t_xorshift_ledger;
        logic [WORD_W-1:0] sx, sy, sz, sw;
        logic [WORD_W-1:0] bit_buf;
        logic [POS_W-1:0]  bit_pos;
        t_answer           owed_results[$];
        int                errors;

        function new();
            errors = 0;
            load_seed('0);
        endfunction

        function void load_seed(logic [WORD_W-1:0] seed);
            sx = seed;
            sy = Y_INIT;
            sz = Z_INIT;
            sw = W_INIT;
            bit_buf = '0;
            bit_pos = BIT_POS_FULL;
        endfunction

        function logic [WORD_W-1:0] next_word();
            logic [WORD_W-1:0] t;
            t = sx ^ (sx << 11);
            sx = sy;
            sy = sz;
            sz = sw;
            sw = sw ^ (sw >> 19) ^ t ^ (t >> 8);
            return sw;
        endfunction

        // trunc toward zero of base + v * span / 2^31, formed exactly
        function logic [WORD_W-1:0] scale_fixed(logic signed [WORD_W-1:0] base,
                                                logic [WORD_W-1:0] v31,
                                                logic signed [WORD_W:0] span);
            logic signed [71:0] b72, v72, d72, num, quo;
            b72 = base;
            v72 = {40'b0, v31};
            d72 = span;
            num = (b72 <<< 31) + v72 * d72;
            quo = num / Q31_ONE;
            return quo[WORD_W-1:0];
        endfunction

        function void take_request(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] lower,
                                   logic [WORD_W-1:0] upper);
            t_answer a;
            logic signed [WORD_W:0] span;
            a = '0;
            case (cmd)
                CMD_RAW: a.word = next_word();
                CMD_MASK31: a.word = next_word() & MASK31;
                CMD_SCALE: begin
                    span = $signed({upper[WORD_W-1], upper});
                    a.scaled = scale_fixed('0, next_word() & MASK31, span);
                end
                CMD_RANGE: begin
                    span = $signed({upper[WORD_W-1], upper}) - $signed({lower[WORD_W-1], lower});
                    a.scaled = scale_fixed(lower, next_word() & MASK31, span);
                end
                CMD_BOOL: begin
                    if (bit_pos >= BIT_POS_FULL) begin
                        bit_buf = next_word();
                        bit_pos = BIT_POS_FIRST;
                    end else begin
                        bit_pos = bit_pos + 1'b1;
                        bit_buf = bit_buf >> 1;
                    end
                    a.word = {31'b0, bit_buf[0]};
                end
                default: ;  // unused codes: no draw, zero result
            endcase
            owed_results.push_back(a);
        endfunction

        function void match_result(logic [WORD_W-1:0] word, logic [WORD_W-1:0] scaled);
            t_answer a;
            if (owed_results.size() == 0) begin
                $error("result: unexpected transfer, word %h scaled %h", word, scaled);
                errors++;
                return;
            end
            a = owed_results.pop_front();
            if (word !== a.word) begin
                $error("word: expected %h, got %h", a.word, word);
                errors++;
            end
            if (scaled !== a.scaled) begin
                $error("scaled: expected %h, got %h", a.scaled, scaled);
                errors++;
            end
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [WORD_W-1:0]   i_cfg_seed;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [CMD_W-1:0]    i_command;
    logic [WORD_W-1:0]   i_lower_bound;
    logic [WORD_W-1:0]   i_upper_bound;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [WORD_W-1:0]   o_word;
    logic [WORD_W-1:0]   o_scaled;

    t_xorshift_ledger ledger = new();
    int send_idle_pct = 0;
    int stall_pct = 0;

    xorshift128_random_source_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_seed    (i_cfg_seed),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_lower_bound (i_lower_bound),
        .i_upper_bound (i_upper_bound),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_word        (o_word),
        .o_scaled      (o_scaled)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // result side: check each transfer, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            ledger.match_result(o_word, o_scaled);
        i_out_stall <= ($urandom_range(99, 0) < stall_pct);
    end

    // Called right after an edge. Valid stays high between back-to-back transfers.
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] lower,
                                logic [WORD_W-1:0] upper);
        if ($urandom_range(99, 0) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_command <= CMD_W'($urandom());
            i_lower_bound <= $urandom();
            i_upper_bound <= $urandom();
            @(posedge i_clk);
            while ($urandom_range(99, 0) < send_idle_pct)
                @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_lower_bound <= lower;
        i_upper_bound <= upper;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        ledger.take_request(cmd, lower, upper);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (ledger.pending() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_seed(logic [WORD_W-1:0] seed);
        i_cfg_we <= 1'b1;
        i_cfg_seed <= seed;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        i_cfg_seed <= $urandom();
        ledger.load_seed(seed);
    endtask

    function automatic logic [WORD_W-1:0] pick_bound();
        case ($urandom_range(9, 0))
            0: return S32_MIN;
            1: return S32_MAX;
            2: return '0;
            3: return ALL_ONES;
            4: return 32'd1;
            5, 6: return $unsigned($signed($urandom_range(200, 0)) - 100);
            default: return $urandom();
        endcase
    endfunction

    task automatic random_requests(int count);
        int sent;
        int run;
        logic [WORD_W-1:0] lo, hi;
        sent = 0;
        while (sent < count) begin
            lo = pick_bound();
            hi = ($urandom_range(9, 0) == 0) ? lo : pick_bound();
            case ($urandom_range(19, 0))
                0, 1: begin
                    // long bool runs so the bit buffer empties and refills
                    run = $urandom_range(70, 33);
                    repeat (run) send_request(CMD_BOOL, $urandom(), $urandom());
                    sent += run;
                end
                2: send_request(CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO)), lo, hi);
                3, 4: begin
                    send_request(CMD_BOOL, lo, hi);
                    sent++;
                end
                default: begin
                    send_request(CMD_W'($urandom_range(CMD_RANGE, CMD_RAW)), lo, hi);
                    sent++;
                end
            endcase
        end
    endtask

    initial begin
        logic [WORD_W-1:0] seeds[6];
        int idle_modes[4][2];
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_seed <= '0;
        i_in_valid <= 1'b0;
        i_command <= CMD_RAW;
        i_lower_bound <= '0;
        i_upper_bound <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset seed, then field extremes and the named corner cases
        send_request(CMD_RAW, '0, '0);
        send_request(CMD_MASK31, ALL_ONES, ALL_ONES);
        send_request(CMD_SCALE, '0, S32_MAX);
        send_request(CMD_SCALE, '0, S32_MIN);
        send_request(CMD_SCALE, ALL_ONES, '0);
        send_request(CMD_SCALE, '0, ALL_ONES);
        send_request(CMD_RANGE, S32_MIN, S32_MAX);  // span needs 33 bits
        send_request(CMD_RANGE, S32_MAX, S32_MIN);  // reversed, full span
        send_request(CMD_RANGE, 32'd100, 32'd100);
        send_request(CMD_RANGE, ALL_ONES, '0);
        send_request(CMD_RANGE, '0, ALL_ONES);
        send_request(CMD_RANGE, 32'd1000, ALL_ONES - 32'd999);
        repeat (4) send_request(CMD_BOOL, '0, '0);
        send_request(CMD_RAW, S32_MIN, S32_MAX);
        send_request(CMD_UNUSED_LO, S32_MAX, S32_MIN);
        send_request(CMD_UNUSED_LO + 3'd1, ALL_ONES, '0);
        send_request(CMD_UNUSED_HI, $urandom(), $urandom());
        send_request(CMD_BOOL, ALL_ONES, ALL_ONES);
        send_request(CMD_MASK31, '0, '0);
        drain();

        seeds = '{S32_MIN, S32_MAX, ALL_ONES, $urandom(), $urandom(), '0};
        idle_modes = '{'{0, 0}, '{67, 0}, '{0, 67}, '{13, 13}};
        for (int p = 0; p < 6; p++) begin
            write_seed(seeds[p]);
            send_idle_pct = idle_modes[p % 4][0];
            stall_pct = idle_modes[p % 4][1];
            random_requests(240);
            drain();
        end

        if (ledger.errors == 0 && ledger.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> xorshift128_random_source_top.f
+incdir+rtl/core
rtl/core/xrs_pkg.sv
rtl/core/xrs_gen.sv
rtl/core/xrs_scale.sv
rtl/core/xorshift128_random_source_top.sv
tb/tb_xorshift128_random_source_top.sv
